// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl file that checks itself
// both macros expect i_clk and i_rst_n in the scope where they are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sjf_pkg.sv =====
// shared types, field widths and controller/datapath interface structs
// for the shortest job first scheduler; no dependencies
`default_nettype none

package sjf_pkg;

    localparam int DEF_MAX_PROCS  = 32;
    localparam int DEF_BURST_BITS = 16;

    localparam int ID_W      = 8;
    localparam int BURST_IO_W = 16;
    localparam int CT_W      = 21;
    localparam int AVG_W     = 29;
    localparam int FRAC_BITS = 8;

    localparam int IN_TDATA_W  = 24;   // id, burst
    localparam int OUT_FIELD_W = ID_W + BURST_IO_W + CT_W + AVG_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic [ID_W-1:0]       t_id;
    typedef logic [BURST_IO_W-1:0] t_burst_io;
    typedef logic [CT_W-1:0]       t_ct;
    typedef logic [AVG_W-1:0]      t_avg;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture incoming record, pos = count
        logic drop;       // store full, flag the batch
        logic probe_rd;   // read entry pos-1
        logic put_new;    // write new record at pos, count++
        logic shift;      // move entry pos-1 up to pos, pos--
        logic emit_rd;    // read entry k
        logic emit_acc;   // accumulate completion and sum
        logic div_start;  // start the average division
        logic out_load;   // fill the output register, k++
        logic batch_clr;  // clear batch state
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic pos_one;
        logic shift_gt;
        logic last_in;
        logic final_k;
        logic out_busy;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/shortest_job_first_scheduler.sv =====
// Non-preemptive shortest job first scheduler.
// Input stream s_axis: one process record per transfer, tdata[7:0] process id,
// tdata[23:8] burst time, tlast on the final record of a batch.
// Output stream m_axis: one transfer per stored process in run order (ascending
// burst, ties in arrival order). tdata carries id, burst, completion time and,
// on the final transfer only, the mean turnaround in fixed point with 8 fraction bits.
// tuser is set on every result of a batch that lost records to a full store.
// Each record is inserted by a shift walk over the store memory, one entry per
// cycle, through the one read port and one write port of the store. After tlast,
// results leave one at a time through the read, accumulate and output states,
// paused by receiver stall; the last one also waits for the divider.
// s_axis_tready stays low until the batch has been emitted; a new batch
// may load while the final result still waits in the output register.
// A stalled receiver holds the output register and pauses emission.
// Reset (synchronous, active low) empties the batch and drops any pending
// result; the store memory itself is not cleared.
`default_nettype none
`include "assert_macros.svh"

module shortest_job_first_scheduler #(
    parameter int MAX_PROCS  = sjf_pkg::DEF_MAX_PROCS,
    parameter int BURST_BITS = sjf_pkg::DEF_BURST_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] process_id, [23:8] burst_time
    input  wire logic [sjf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [7:0] run_id, [23:8] run_burst, [44:24] completion_time,
    // [73:45] average_turnaround, [79:74] zero
    output logic      [sjf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] overflow
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    sjf_pkg::t_cmd w_cmd;
    sjf_pkg::t_sts w_sts;

    sjf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sjf_dp #(
        .MAX_PROCS  (MAX_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_in_tdata   (s_axis_tdata),
        .i_in_tlast   (s_axis_tlast),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata),
        .o_out_tuser  (m_axis_tuser),
        .o_out_tlast  (m_axis_tlast)
    );

    `ASSERT_IMP(a_no_overwrite, w_cmd.out_load, !m_axis_tvalid, "output register overwritten")
    `ASSERT_NXT(a_div_runs, w_cmd.div_start, !w_sts.div_done, "divider did not start")
    `ASSERT_IMP(a_avg_only_last, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[73:45] == 29'd0,
        "average set on a non-final result")

endmodule

`default_nettype wire

// ===== hw/rtl/sjf_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module sjf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sjf_div.sv =====
// restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module sjf_div #(
    parameter int DIVIDEND_W = 34,
    parameter int DIVISOR_W  = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic      [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;

    assign rem_sh  = {r_rem, r_quo[DIVIDEND_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign ge      = (rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/sjf_dp.sv =====
// datapath: sorted record store, completion and turnaround accumulators,
// average divider and output register; uses sjf_pkg, sjf_ram, sjf_div
`default_nettype none

module sjf_dp #(
    parameter int MAX_PROCS  = sjf_pkg::DEF_MAX_PROCS,
    parameter int BURST_BITS = sjf_pkg::DEF_BURST_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire sjf_pkg::t_cmd                    i_cmd,
    output sjf_pkg::t_sts                         o_sts,
    input  wire logic [sjf_pkg::IN_TDATA_W-1:0]   i_in_tdata,
    input  wire logic                             i_in_tlast,
    input  wire logic                             i_out_tready,
    output logic                                  o_out_tvalid,
    output logic      [sjf_pkg::OUT_TDATA_W-1:0]  o_out_tdata,
    output logic                                  o_out_tuser,
    output logic                                  o_out_tlast
);

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int AW    = $clog2(MAX_PROCS);
    localparam int CW    = BURST_BITS + CNT_W;
    localparam int SW    = CW + CNT_W;
    localparam int DW    = SW + sjf_pkg::FRAC_BITS;
    localparam int EW    = sjf_pkg::ID_W + BURST_BITS;
    localparam int PAD_W = sjf_pkg::OUT_TDATA_W - sjf_pkg::OUT_FIELD_W;

    typedef logic [BURST_BITS-1:0] t_burst;

    sjf_pkg::t_id        r_id_in;
    t_burst              r_burst_in;
    logic                r_last_in;
    logic [CNT_W-1:0]    r_count;
    logic                r_dropped;
    logic [CNT_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_k;
    logic [CW-1:0]       r_compl;
    logic [SW-1:0]       r_sum;

    logic                r_out_valid;
    sjf_pkg::t_id        r_out_id;
    sjf_pkg::t_burst_io  r_out_burst;
    sjf_pkg::t_ct        r_out_ct;
    sjf_pkg::t_avg       r_out_avg;
    logic                r_out_ovf;
    logic                r_out_last;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [EW-1:0]       wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [EW-1:0]       rd_data;
    sjf_pkg::t_id        rd_id;
    t_burst              rd_burst;
    logic [CW-1:0]       compl_next;
    logic                final_k;
    logic                div_busy;
    logic [DW-1:0]       quotient;

    assign rd_id    = rd_data[sjf_pkg::ID_W-1:0];
    assign rd_burst = rd_data[EW-1:sjf_pkg::ID_W];

    assign final_k    = ((r_k + CNT_W'(1)) == r_count);
    assign compl_next = r_compl + CW'(rd_burst);

    // store port steering: the shift walk reads pos-2 while writing pos
    assign wr_en   = i_cmd.put_new | i_cmd.shift;
    assign wr_addr = AW'(r_pos);
    assign wr_data = i_cmd.put_new ? {r_burst_in, r_id_in} : rd_data;
    assign rd_en   = i_cmd.probe_rd | i_cmd.emit_rd | (i_cmd.shift & (r_pos > CNT_W'(1)));

    always_comb begin
        if (i_cmd.emit_rd) begin
            rd_addr = AW'(r_k);
        end else if (i_cmd.probe_rd) begin
            rd_addr = AW'(r_pos - CNT_W'(1));
        end else begin
            rd_addr = AW'(r_pos - CNT_W'(2));
        end
    end

    sjf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    sjf_div #(
        .DIVIDEND_W (DW),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_sum, {sjf_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // batch control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_pos     <= '0;
            r_k       <= '0;
            r_compl   <= '0;
            r_sum     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_pos <= r_count;
            end else if (i_cmd.shift) begin
                r_pos <= r_pos - CNT_W'(1);
            end
            if (i_cmd.put_new) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.drop) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.emit_acc) begin
                r_compl <= compl_next;
                r_sum   <= r_sum + SW'(compl_next);
            end
            if (i_cmd.out_load && !i_cmd.batch_clr) begin
                r_k <= r_k + CNT_W'(1);
            end
            if (i_cmd.batch_clr) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
                r_k       <= '0;
                r_compl   <= '0;
                r_sum     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id_in    <= i_in_tdata[sjf_pkg::ID_W-1:0];
            r_burst_in <= t_burst'(i_in_tdata[sjf_pkg::IN_TDATA_W-1:sjf_pkg::ID_W]);
            r_last_in  <= i_in_tlast;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_id    <= rd_id;
            r_out_burst <= sjf_pkg::t_burst_io'(rd_burst);
            r_out_ct    <= sjf_pkg::t_ct'(r_compl);
            r_out_avg   <= final_k ? sjf_pkg::t_avg'(quotient) : '0;
            r_out_ovf   <= r_dropped;
            r_out_last  <= final_k;
        end
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tdata  = {{PAD_W{1'b0}}, r_out_avg, r_out_ct, r_out_burst, r_out_id};
    assign o_out_tuser  = r_out_ovf;
    assign o_out_tlast  = r_out_last;

    always_comb begin
        o_sts          = '0;
        o_sts.full     = (r_count == CNT_W'(MAX_PROCS));
        o_sts.pos_zero = (r_pos == '0);
        o_sts.pos_one  = (r_pos == CNT_W'(1));
        o_sts.shift_gt = (rd_burst > r_burst_in);
        o_sts.last_in  = r_last_in;
        o_sts.final_k  = final_k;
        o_sts.out_busy = r_out_valid;
        o_sts.div_done = !div_busy;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sjf_ctrl.sv =====
// controller: sequences record insertion, result emission and averaging
// uses sjf_pkg
`default_nettype none

module sjf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sjf_pkg::t_sts i_sts,
    output sjf_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PROBE     = 3'd1;
    localparam logic [2:0] S_SHIFT     = 3'd2;
    localparam logic [2:0] S_RD        = 3'd3;
    localparam logic [2:0] S_ACC       = 3'd4;
    localparam logic [2:0] S_DIV_START = 3'd5;
    localparam logic [2:0] S_DIV_WAIT  = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] after_insert;

    assign o_in_ready   = (r_state == S_IDLE);
    assign after_insert = i_sts.last_in ? S_RD : S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.full) begin
                    o_cmd.drop = 1'b1;
                    n_state    = after_insert;
                end else if (i_sts.pos_zero) begin
                    o_cmd.put_new = 1'b1;
                    n_state       = after_insert;
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // equal bursts stay ahead, so only strictly larger ones move
                if (i_sts.shift_gt) begin
                    o_cmd.shift = 1'b1;
                    n_state     = i_sts.pos_one ? S_PROBE : S_SHIFT;
                end else begin
                    o_cmd.put_new = 1'b1;
                    n_state       = after_insert;
                end
            end
            S_RD: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.emit_acc = 1'b1;
                n_state        = i_sts.final_k ? S_DIV_START : S_OUT;
            end
            S_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
                if (i_sts.final_k) begin
                    o_cmd.batch_clr = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench for shortest_job_first_scheduler: feeds batches of process records,
// predicts run order, completion times and mean turnaround, checks every result
// depends on sjf_pkg and the scheduler rtl

module testbench;

    localparam int STORE_DEPTH   = sjf_pkg::DEF_MAX_PROCS;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 365;
    localparam int BURST_LSB     = sjf_pkg::ID_W;
    localparam int CT_LSB        = sjf_pkg::ID_W + sjf_pkg::BURST_IO_W;
    localparam int AVG_LSB       = CT_LSB + sjf_pkg::CT_W;

    typedef enum int {MIX_FULL, MIX_TIES, MIX_EDGES, MIX_NARROW} t_burst_mix;

    typedef struct {
        sjf_pkg::t_id       id;
        sjf_pkg::t_burst_io burst;
        sjf_pkg::t_ct       finish;
        sjf_pkg::t_avg      mean_tat;
        logic               dropped;
        logic               final_run;
    } t_run_slot;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sjf_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sjf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;

    // scheduler copy: batch being loaded, kept sorted by burst
    sjf_pkg::t_id       batch_id [STORE_DEPTH];
    sjf_pkg::t_burst_io batch_burst [STORE_DEPTH];
    int                 batch_count = 0;
    bit                 batch_dropped = 1'b0;

    t_run_slot pending_runs [$];
    int        err_count = 0;
    bit        tx_stall_en = 1'b0;
    bit        rx_stall_en = 1'b0;
    int        rx_hold_len = 0;

    shortest_job_first_scheduler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 13) return 0;
        if (roll < 18) return $urandom_range(1, 4);
        return $urandom_range(15, 50);
    endfunction

    function automatic sjf_pkg::t_burst_io pick_burst(input t_burst_mix mix);
        case (mix)
            MIX_TIES:   return sjf_pkg::t_burst_io'($urandom_range(0, 7));
            MIX_EDGES:  return $urandom_range(0, 1) ?
                               sjf_pkg::t_burst_io'(16'hFFFF - $urandom_range(0, 1)) :
                               sjf_pkg::t_burst_io'($urandom_range(0, 1));
            MIX_NARROW: return sjf_pkg::t_burst_io'($urandom_range(1000, 1015));
            default:    return sjf_pkg::t_burst_io'($urandom);
        endcase
    endfunction

    // insert one accepted record; on the closing record, queue the whole run order
    task automatic admit_record(input sjf_pkg::t_id pid, input sjf_pkg::t_burst_io burst,
                                input logic lst);
        int          pos;
        logic [63:0] finish;
        logic [63:0] total;
        t_run_slot   slot;
        if (batch_count < STORE_DEPTH) begin
            pos = batch_count;
            // equal bursts stay ahead of the newcomer
            while (pos > 0 && batch_burst[pos-1] > burst) begin
                batch_id[pos]    = batch_id[pos-1];
                batch_burst[pos] = batch_burst[pos-1];
                pos--;
            end
            batch_id[pos]    = pid;
            batch_burst[pos] = burst;
            batch_count++;
        end else begin
            batch_dropped = 1'b1;
        end
        if (lst) begin
            finish = '0;
            total  = '0;
            for (int k = 0; k < batch_count; k++) begin
                finish         = finish + 64'(batch_burst[k]);
                total          = total + finish;
                slot.id        = batch_id[k];
                slot.burst     = batch_burst[k];
                slot.finish    = sjf_pkg::t_ct'(finish);
                slot.final_run = (k == batch_count - 1);
                slot.mean_tat  = slot.final_run ?
                                 sjf_pkg::t_avg'((total << sjf_pkg::FRAC_BITS) /
                                                 64'(batch_count)) : '0;
                slot.dropped   = batch_dropped;
                pending_runs.push_back(slot);
            end
            batch_count   = 0;
            batch_dropped = 1'b0;
        end
    endtask

    task automatic send_record(input sjf_pkg::t_id pid, input sjf_pkg::t_burst_io burst,
                               input logic lst);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {burst, pid};
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        admit_record(pid, burst, lst);
        gap = tx_stall_en ? idle_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic await_all_runs();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_run_slot want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_runs.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual id %0d",
                         $time, m_axis_tdata[sjf_pkg::ID_W-1:0]);
                err_count++;
            end else begin
                want = pending_runs.pop_front();
                check_field("run_id", 32'(want.id), 32'(m_axis_tdata[sjf_pkg::ID_W-1:0]));
                check_field("run_burst", 32'(want.burst),
                            32'(m_axis_tdata[BURST_LSB +: sjf_pkg::BURST_IO_W]));
                check_field("completion_time", 32'(want.finish),
                            32'(m_axis_tdata[CT_LSB +: sjf_pkg::CT_W]));
                check_field("average_turnaround", 32'(want.mean_tat),
                            32'(m_axis_tdata[AVG_LSB +: sjf_pkg::AVG_W]));
                check_field("overflow", 32'(want.dropped), 32'(m_axis_tuser));
                check_field("last_result", 32'(want.final_run), 32'(m_axis_tlast));
            end
        end
    end

    initial begin : receiver_pacing
        int hold;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len > 0) begin
                hold = rx_hold_len;
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
                rx_hold_len = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (idle_gap() + 1) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_single_records();
        tx_stall_en = 1'b0;
        rx_stall_en = 1'b0;
        send_record(8'hFF, 16'hFFFF, 1'b1);
        send_record(8'h00, 16'h0000, 1'b1);
        await_all_runs();
    endtask

    task automatic test_ties_and_extremes();
        send_record(8'h01, 16'h0007, 1'b0);
        send_record(8'h80, 16'hFFFF, 1'b0);
        send_record(8'hFE, 16'h0000, 1'b0);
        send_record(8'h7F, 16'h0007, 1'b0);
        send_record(8'h55, 16'h8000, 1'b0);
        send_record(8'hAA, 16'h0000, 1'b1);
        await_all_runs();
    endtask

    // descending bursts make every insert walk the whole batch
    task automatic test_reverse_order();
        tx_stall_en = 1'b1;
        rx_stall_en = 1'b1;
        for (int n = 0; n < 8; n++)
            send_record(sjf_pkg::t_id'($urandom),
                        sjf_pkg::t_burst_io'(16'hF000 - n * 16'h1234), n == 7);
        await_all_runs();
    endtask

    task automatic test_store_full();
        tx_stall_en = 1'b0;
        rx_stall_en = 1'b0;
        // exactly full with the widest bursts: largest completion and average
        for (int n = 0; n < STORE_DEPTH; n++)
            send_record(sjf_pkg::t_id'(n), 16'hFFFF, n == STORE_DEPTH - 1);
        await_all_runs();
        // two records over capacity, the closing one among the dropped
        tx_stall_en = 1'b1;
        rx_stall_en = 1'b1;
        for (int n = 0; n < STORE_DEPTH + 2; n++)
            send_record(sjf_pkg::t_id'($urandom), sjf_pkg::t_burst_io'($urandom),
                        n == STORE_DEPTH + 1);
        await_all_runs();
        // flag must be gone in the next batch
        send_record(8'h3C, 16'h0102, 1'b0);
        send_record(8'hC3, 16'h0101, 1'b1);
        await_all_runs();
    endtask

    task automatic test_output_backpressure();
        tx_stall_en = 1'b0;
        rx_stall_en = 1'b0;
        // long receiver hold-off: the output register fills and input transfers stop
        rx_hold_len = 600;
        for (int n = 0; n < 5; n++)
            send_record(sjf_pkg::t_id'(n + 10), sjf_pkg::t_burst_io'(500 - n * 100), n == 4);
        for (int n = 0; n < 5; n++)
            send_record(sjf_pkg::t_id'(n + 20), sjf_pkg::t_burst_io'($urandom_range(0, 3)),
                        n == 4);
        await_all_runs();
    endtask

    task automatic test_random_batches();
        int         sent;
        int         batch_len;
        int         roll;
        t_burst_mix mix;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                batch_len = $urandom_range(1, 10);
            else if (roll < 94)
                batch_len = $urandom_range(11, STORE_DEPTH - 1);
            else
                batch_len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 4);
            mix = t_burst_mix'($urandom_range(0, 3));
            tx_stall_en = ($urandom_range(0, 4) != 0);
            rx_stall_en = ($urandom_range(0, 4) != 0);
            for (int n = 0; n < batch_len; n++)
                send_record(sjf_pkg::t_id'($urandom), pick_burst(mix), n == batch_len - 1);
            sent += batch_len;
            if ($urandom_range(0, 9) == 0) await_all_runs();
        end
        await_all_runs();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_single_records();
        test_ties_and_extremes();
        test_reverse_order();
        test_store_full();
        test_output_backpressure();
        test_random_batches();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("%0t: timeout", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sjf_pkg.sv
hw/rtl/sjf_ram.sv
hw/rtl/sjf_div.sv
hw/rtl/sjf_dp.sv
hw/rtl/sjf_ctrl.sv
hw/rtl/shortest_job_first_scheduler.sv
test/testbench.sv
